FILE: src/assert_macros.svh
// Assertion macros shared by the posting-list intersection RTL.
// Included by name from each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("posting list intersection: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PLI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("posting list intersection: next-cycle check failed");

`endif

FILE: src/pli_pkg.sv
// Package for the posting-list intersection block: sizes, command codes,
// item structs and the compare-unit result type. No dependencies.
package pli_pkg;

  // Store size and list limit
  localparam int DOC_COUNT = 1024;
  localparam int MAX_LISTS = 15;

  localparam int ADDR_W  = (DOC_COUNT > 1) ? $clog2(DOC_COUNT) : 1;
  localparam int CUR_W   = ADDR_W + 1;
  localparam int LVL_W   = $clog2(MAX_LISTS + 1);
  localparam int DOC_W   = 10;

  // Command codes
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_POST  = 2'd1,
    CMD_END   = 2'd2,
    CMD_FETCH = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [DOC_W-1:0] doc_id;
  } in_item_t;

  typedef struct packed {
    logic [DOC_W-1:0] doc_id_res;
    logic             valid_res;
    logic             overflow;
  } out_item_t;

  // Shared compare unit result
  typedef struct packed {
    logic             eq;
    logic [LVL_W-1:0] next_level;
  } lvl_cmp_t;

endpackage

FILE: src/pli_level_ram.sv
// Match-level store: one level per document, one write and one read port,
// registered read data. Depends on pli_pkg.
module pli_level_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [pli_pkg::ADDR_W-1:0] waddr,
  input  logic [pli_pkg::LVL_W-1:0]  wdata,
  input  logic                      re,
  input  logic [pli_pkg::ADDR_W-1:0] raddr,
  output logic [pli_pkg::LVL_W-1:0]  rdata
);

  logic [pli_pkg::LVL_W-1:0] mem [pli_pkg::DOC_COUNT];
  logic [pli_pkg::LVL_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/pli_level_cmp.sv
// Shared level compare unit: tests a stored level against the list count
// and forms the raised level. Used by postings and by the fetch scan.
// Depends on pli_pkg.
module pli_level_cmp (
  input  logic [pli_pkg::LVL_W-1:0] level,
  input  logic [pli_pkg::LVL_W-1:0] lists_done,
  output pli_pkg::lvl_cmp_t         res
);

  always_comb begin
    res.eq         = (level == lists_done);
    res.next_level = lists_done + pli_pkg::LVL_W'(1);
  end

endmodule

FILE: src/posting_list_intersection.sv
// Posting-list intersection top level: command sequencer, cursor and list
// counters, result register. Uses pli_pkg, pli_level_ram, pli_level_cmp
// and assert_macros.svh.
//
//  channel  ports                          handshake
//  -------  -----------------------------  ---------------------------------
//  input    start, busy, in_item           taken when start && !busy
//  result   out_strobe, out_item           one cycle per result, no stall
//
// After reset and after every start command the store is cleared one entry
// a cycle, with busy high.
// A posting reads, then conditionally writes, one entry; an ignored posting
// leaves the store alone. An end-of-list command gives no result.
// A fetch scans the store one entry per cycle; its result appears
// the cycle after the scan stops. The receiver cannot stall.
`include "assert_macros.svh"

module posting_list_intersection (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pli_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output pli_pkg::out_item_t  out_item
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_POST  = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  localparam logic [pli_pkg::ADDR_W-1:0] LAST_ADDR = pli_pkg::ADDR_W'(pli_pkg::DOC_COUNT - 1);
  localparam logic [pli_pkg::CUR_W-1:0]  CUR_END   = pli_pkg::CUR_W'(pli_pkg::DOC_COUNT);
  localparam logic [pli_pkg::LVL_W-1:0]  LVL_MAX   = pli_pkg::LVL_W'(pli_pkg::MAX_LISTS);

  state_t                      state_r, state_nxt;
  logic [pli_pkg::LVL_W-1:0]   lists_done_r, lists_done_nxt;
  logic                        overflow_r, overflow_nxt;
  logic [pli_pkg::CUR_W-1:0]   cursor_r, cursor_nxt;
  logic [pli_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [pli_pkg::ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic                        out_strobe_r, out_strobe_nxt;
  pli_pkg::out_item_t          out_item_r, out_item_nxt;

  logic                        accept;
  logic                        doc_ok;
  logic                        post_ok;
  logic                        ram_we;
  logic [pli_pkg::ADDR_W-1:0]  ram_waddr;
  logic [pli_pkg::LVL_W-1:0]   ram_wdata;
  logic                        ram_re;
  logic [pli_pkg::ADDR_W-1:0]  ram_raddr;
  logic [pli_pkg::LVL_W-1:0]   ram_rdata;
  pli_pkg::lvl_cmp_t           cmp;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign doc_ok = (32'(in_item.doc_id) < 32'(pli_pkg::DOC_COUNT));
  assign post_ok = !overflow_r && (lists_done_r < LVL_MAX) && doc_ok;

  pli_level_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pli_level_cmp u_cmp (
    .level      (ram_rdata),
    .lists_done (lists_done_r),
    .res        (cmp)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    lists_done_nxt = lists_done_r;
    overflow_nxt   = overflow_r;
    cursor_nxt     = cursor_r;
    addr_nxt       = addr_r;
    clr_addr_nxt   = clr_addr_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = cmp.next_level;
    ram_re         = 1'b0;
    ram_raddr      = cursor_r[pli_pkg::ADDR_W-1:0];

    case (state_r)
      S_CLEAR: begin
        // zero one entry a cycle
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + pli_pkg::ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (in_item.cmd)
            pli_pkg::CMD_START: begin
              lists_done_nxt = '0;
              overflow_nxt   = 1'b0;
              cursor_nxt     = '0;
              clr_addr_nxt   = '0;
              state_nxt      = S_CLEAR;
            end
            pli_pkg::CMD_POST: begin
              if (post_ok) begin
                ram_re    = 1'b1;
                ram_raddr = pli_pkg::ADDR_W'(in_item.doc_id);
                addr_nxt  = pli_pkg::ADDR_W'(in_item.doc_id);
                state_nxt = S_POST;
              end
            end
            pli_pkg::CMD_END: begin
              if (lists_done_r >= LVL_MAX) begin
                overflow_nxt = 1'b1;
              end else begin
                lists_done_nxt = lists_done_r + pli_pkg::LVL_W'(1);
              end
            end
            pli_pkg::CMD_FETCH: begin
              if (overflow_r || (lists_done_r == '0) || (cursor_r == CUR_END)) begin
                // nothing to scan: answer at once
                out_strobe_nxt          = 1'b1;
                out_item_nxt.doc_id_res = '0;
                out_item_nxt.valid_res  = 1'b0;
                out_item_nxt.overflow   = overflow_r;
              end else begin
                ram_re     = 1'b1;
                addr_nxt   = cursor_r[pli_pkg::ADDR_W-1:0];
                cursor_nxt = cursor_r + pli_pkg::CUR_W'(1);
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_POST: begin
        // raise level k-1 to k
        ram_we    = cmp.eq;
        state_nxt = S_IDLE;
      end

      S_SCAN: begin
        // ram_rdata holds the level of document addr_r
        if (cmp.eq) begin
          out_strobe_nxt          = 1'b1;
          out_item_nxt.doc_id_res = pli_pkg::DOC_W'(addr_r);
          out_item_nxt.valid_res  = 1'b1;
          out_item_nxt.overflow   = overflow_r;
          state_nxt               = S_IDLE;
        end else if (cursor_r == CUR_END) begin
          out_strobe_nxt          = 1'b1;
          out_item_nxt.doc_id_res = '0;
          out_item_nxt.valid_res  = 1'b0;
          out_item_nxt.overflow   = overflow_r;
          state_nxt               = S_IDLE;
        end else begin
          ram_re     = 1'b1;
          addr_nxt   = cursor_r[pli_pkg::ADDR_W-1:0];
          cursor_nxt = cursor_r + pli_pkg::CUR_W'(1);
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      lists_done_r <= '0;
      overflow_r   <= 1'b0;
      cursor_r     <= '0;
      clr_addr_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lists_done_r <= lists_done_nxt;
      overflow_r   <= overflow_nxt;
      cursor_r     <= cursor_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // checks
  `PLI_ASSERT_IMP(a_hit_no_ovf, clk, rst_n, out_strobe_r && out_item_r.valid_res,
                  !out_item_r.overflow)
  `PLI_ASSERT_IMP(a_scan_legal, clk, rst_n, state_r == S_SCAN,
                  (lists_done_r != '0) && !overflow_r)
  `PLI_ASSERT_NXT(a_start_clears, clk, rst_n, accept && (in_item.cmd == pli_pkg::CMD_START),
                  (state_r == S_CLEAR) && (cursor_r == '0) && (lists_done_r == '0))
  `PLI_ASSERT_IMP(a_lists_bound, clk, rst_n, 1'b1, lists_done_r <= LVL_MAX)

endmodule

FILE: tb/sv/posting_list_intersection_test.sv
// Self-checking testbench for posting_list_intersection: directed and random queries.
// Predicts every fetch result in SystemVerilog and compares it field by field.
// Depends on pli_pkg and the posting_list_intersection RTL.
`timescale 1ns / 1ps

module posting_list_intersection_test;

  // Stall limit: store clear or full scan, plus sender gap, with margin
  localparam int STALL_LIMIT = 4 * (pli_pkg::DOC_COUNT + 32);
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_ITEMS = 650;
  localparam int TOTAL_ITEMS = 850;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  pli_pkg::in_item_t  in_item = '0;
  logic               out_strobe;
  pli_pkg::out_item_t out_item;

  // Predicted query state
  logic [pli_pkg::LVL_W-1:0] doc_level [pli_pkg::DOC_COUNT];
  logic [pli_pkg::LVL_W-1:0] lists_closed;
  bit                        lists_over;
  logic [pli_pkg::CUR_W-1:0] scan_pos;

  pli_pkg::out_item_t expected_results[$];
  pli_pkg::out_item_t want;
  int                 failures = 0;
  int                 items_sent = 0;
  bit                 idle_en = 1'b1;

  posting_list_intersection u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic pli_pkg::in_item_t make_item(pli_pkg::cmd_t c,
                                                  logic [pli_pkg::DOC_W-1:0] d);
    pli_pkg::in_item_t it;
    it.cmd = c;
    it.doc_id = d;
    return it;
  endfunction

  task automatic clear_query_state();
    for (int k = 0; k < pli_pkg::DOC_COUNT; k++) doc_level[k] = '0;
    lists_closed = '0;
    lists_over = 1'b0;
    scan_pos = '0;
  endtask

  // Update the predicted state with one accepted item; queue a fetch result
  task automatic predict_intersection(pli_pkg::in_item_t it);
    pli_pkg::out_item_t r;
    bit                 hit;
    r = '0;
    hit = 1'b0;
    case (it.cmd)
      pli_pkg::CMD_START: clear_query_state();
      pli_pkg::CMD_POST: begin
        if (!lists_over && lists_closed < pli_pkg::MAX_LISTS &&
            it.doc_id < pli_pkg::DOC_COUNT) begin
          if (doc_level[it.doc_id] == lists_closed)
            doc_level[it.doc_id] = lists_closed + 1'b1;
        end
      end
      pli_pkg::CMD_END: begin
        if (lists_closed >= pli_pkg::MAX_LISTS) lists_over = 1'b1;
        else lists_closed = lists_closed + 1'b1;
      end
      pli_pkg::CMD_FETCH: begin
        if (!lists_over && lists_closed != 0) begin
          while (scan_pos < pli_pkg::DOC_COUNT && !hit) begin
            if (doc_level[scan_pos[pli_pkg::ADDR_W-1:0]] == lists_closed) begin
              hit = 1'b1;
              r.doc_id_res = scan_pos[pli_pkg::DOC_W-1:0];
            end
            scan_pos = scan_pos + 1'b1;
          end
        end
        r.valid_res = hit;
        r.overflow = lists_over;
        expected_results.insert(expected_results.size(), r);
      end
      default: begin
      end
    endcase
  endtask

  // Send one item; wait for acceptance, then maybe idle for a random burst
  task automatic send_item(pli_pkg::cmd_t c, logic [pli_pkg::DOC_W-1:0] d);
    pli_pkg::in_item_t it;
    it = make_item(c, d);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predict_intersection(it);
    items_sent++;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Hold the sender until every predicted result has come back
  task automatic wait_results_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Result checker: the receiver never stalls
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: doc_id_res %0d valid_res %0d overflow %0d",
               out_item.doc_id_res, out_item.valid_res, out_item.overflow);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.doc_id_res !== want.doc_id_res) begin
          $error("doc_id_res: expected %0d, got %0d", want.doc_id_res, out_item.doc_id_res);
          failures++;
        end
        if (out_item.valid_res !== want.valid_res) begin
          $error("valid_res: expected %0d, got %0d", want.valid_res, out_item.valid_res);
          failures++;
        end
        if (out_item.overflow !== want.overflow) begin
          $error("overflow: expected %0d, got %0d", want.overflow, out_item.overflow);
          failures++;
        end
      end
    end
  end

  // Watchdog: cycles with neither an accepted item nor a result
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_strobe) stalled = 0;
      else stalled++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Fetch with no lists, extreme IDs, duplicates, exhaustion, empty list
  task automatic test_basic_intersection();
    send_item(pli_pkg::CMD_FETCH, 10'd0);
    send_item(pli_pkg::CMD_START, 10'd0);
    send_item(pli_pkg::CMD_POST, 10'd0);
    send_item(pli_pkg::CMD_POST, 10'd1023);
    send_item(pli_pkg::CMD_POST, 10'd5);
    send_item(pli_pkg::CMD_POST, 10'd5);
    send_item(pli_pkg::CMD_POST, 10'h2AA);
    send_item(pli_pkg::CMD_END, 10'd0);
    send_item(pli_pkg::CMD_POST, 10'd1023);
    send_item(pli_pkg::CMD_POST, 10'd5);
    send_item(pli_pkg::CMD_POST, 10'h155);
    send_item(pli_pkg::CMD_END, 10'h3FF);
    send_item(pli_pkg::CMD_FETCH, 10'd0);
    // posting after a fetch: cursor stays where it stopped
    send_item(pli_pkg::CMD_POST, 10'd1023);
    send_item(pli_pkg::CMD_END, 10'd0);
    send_item(pli_pkg::CMD_FETCH, 10'h3FF);
    send_item(pli_pkg::CMD_FETCH, 10'd0);
    send_item(pli_pkg::CMD_FETCH, 10'd0);
    // an empty list empties the result
    send_item(pli_pkg::CMD_START, 10'd0);
    send_item(pli_pkg::CMD_POST, 10'd3);
    send_item(pli_pkg::CMD_END, 10'd0);
    send_item(pli_pkg::CMD_END, 10'd0);
    send_item(pli_pkg::CMD_FETCH, 10'd0);
  endtask

  // Fill every list slot, then one list too many
  task automatic test_list_overflow();
    send_item(pli_pkg::CMD_START, 10'd0);
    for (int k = 0; k < pli_pkg::MAX_LISTS; k++) begin
      send_item(pli_pkg::CMD_POST, 10'd9);
      send_item(pli_pkg::CMD_END, 10'd0);
    end
    send_item(pli_pkg::CMD_POST, 10'd4);       // ignored: all list slots used
    send_item(pli_pkg::CMD_FETCH, 10'd0);
    send_item(pli_pkg::CMD_END, 10'd0);        // sets the overflow flag
    send_item(pli_pkg::CMD_POST, 10'd9);
    send_item(pli_pkg::CMD_FETCH, 10'd0);
    send_item(pli_pkg::CMD_FETCH, 10'd0);
  endtask

  // One well-formed query with random content and some noise
  task automatic run_random_query(bit drain_first);
    logic [pli_pkg::DOC_W-1:0] pool [12];
    int                        n_lists;
    int                        n_posts;
    int                        n_fetch;
    for (int k = 0; k < 12; k++)
      pool[k] = pli_pkg::DOC_W'($urandom_range(0, pli_pkg::DOC_COUNT - 1));
    if ($urandom_range(0, 3) == 0) pool[0] = '0;
    if ($urandom_range(0, 3) == 0) pool[1] = '1;
    send_item(pli_pkg::CMD_START, pli_pkg::DOC_W'($urandom));
    if ($urandom_range(0, 9) == 0)
      n_lists = $urandom_range(pli_pkg::MAX_LISTS - 1, pli_pkg::MAX_LISTS + 2);
    else n_lists = $urandom_range(1, 4);
    for (int l = 0; l < n_lists; l++) begin
      n_posts = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(2, 10);
      for (int p = 0; p < n_posts; p++) begin
        if ($urandom_range(0, 11) == 0) begin
          // noise: fetch mid-load, stray end or posting
          case ($urandom_range(0, 2))
            0: send_item(pli_pkg::CMD_FETCH, pli_pkg::DOC_W'($urandom));
            1: send_item(pli_pkg::CMD_END, pli_pkg::DOC_W'($urandom));
            default: send_item(pli_pkg::CMD_POST, pli_pkg::DOC_W'($urandom));
          endcase
        end else if ($urandom_range(0, 3) == 0) begin
          send_item(pli_pkg::CMD_POST, pli_pkg::DOC_W'($urandom));
        end else begin
          send_item(pli_pkg::CMD_POST, pool[$urandom_range(0, 11)]);
        end
      end
      send_item(pli_pkg::CMD_END, pli_pkg::DOC_W'($urandom));
    end
    if (drain_first) wait_results_drained();
    n_fetch = $urandom_range(1, 10);
    for (int f = 0; f < n_fetch; f++) send_item(pli_pkg::CMD_FETCH, pli_pkg::DOC_W'($urandom));
    // late posting and list after fetches
    if ($urandom_range(0, 4) == 0) begin
      send_item(pli_pkg::CMD_POST, pool[$urandom_range(0, 11)]);
      send_item(pli_pkg::CMD_END, '0);
      send_item(pli_pkg::CMD_FETCH, '0);
      send_item(pli_pkg::CMD_FETCH, '0);
    end
  endtask

  task automatic test_random_queries();
    idle_en = 1'b1;
    while (items_sent < RANDOM_ITEMS) run_random_query(1'b0);
  endtask

  task automatic test_pause_until_drained();
    wait_results_drained();
    run_random_query(1'b1);
  endtask

  task automatic test_back_to_back_queries();
    idle_en = 1'b0;
    while (items_sent < TOTAL_ITEMS) run_random_query(1'b0);
  endtask

  initial begin
    clear_query_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_intersection();
    test_list_overflow();
    test_random_queries();
    test_pause_until_drained();
    test_back_to_back_queries();
    wait_results_drained();
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
